// ===== hw/rtl/efd_pkg.sv =====
package efd_pkg;

  // largest frame the byte counter covers
  localparam int unsigned MAX_FRAME = 64;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [LEN_W-1:0] MAX_FRAME_LEN = LEN_W'(MAX_FRAME);

  // control characters on the line
  localparam logic [BYTE_W-1:0] CH_START = 8'hA0;
  localparam logic [BYTE_W-1:0] CH_STOP  = 8'hA5;
  localparam logic [BYTE_W-1:0] CH_SHAKE = 8'hA6;
  localparam logic [BYTE_W-1:0] CH_ESC   = 8'hAA;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 1'b1;

  localparam logic [CFG_W-1:0] MAX_LENGTH_RST = 7'd47;
  localparam logic [CFG_W-1:0] MIN_LENGTH_RST = 7'd8;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ABORT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_HDR   = 3'd2,
    ST_BODY  = 3'd3,
    ST_ESC   = 3'd4,
    ST_LONG  = 3'd5
  } status_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [IDX_W-1:0]  byte_index;
    status_t           status;
    logic [LEN_W-1:0]  frame_length;
  } res_t;

  typedef struct packed {
    logic              hit;
    logic [BYTE_W-1:0] plain;
  } esc_t;

  // maps an escaped code back to its plain byte
  function automatic esc_t esc_decode(input logic [BYTE_W-1:0] code);
    esc_t r;
    r.hit = 1'b1;
    unique case (code)
      8'hB0:   r.plain = 8'hA0;
      8'hB5:   r.plain = 8'hA5;
      8'hB6:   r.plain = 8'hA6;
      8'hBA:   r.plain = 8'hAA;
      8'h3B:   r.plain = 8'h1B;
      default: begin
        r.hit   = 1'b0;
        r.plain = '0;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/escaped_frame_deframer_checker_unit.sv =====
// Escaped serial frame deframer and checker. Takes one received byte per
// transaction: 0xA0 opens (or reopens) a frame, 0xA5 closes it, 0xA6 is dropped
// and 0xAA escapes the next byte, which is mapped back through a five-entry
// table. Each payload byte comes out with its index; the stop byte gives an end
// transaction whose status checks minimum length, the header sum of bytes 0..2
// and the body sum of bytes 3..end. A bad escape or an overlong frame gives an
// abort transaction. Throughput is one byte per clock when out_stall is low;
// a byte passes the input register, the frame state update and the result
// register; bytes giving no result take a slot too. Configuration must be
// written only while idle (not enforced); max_length is clipped to 64.
module escaped_frame_deframer_checker_unit (
  input  logic                          clk,
  input  logic                          rst,
  // input byte channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [efd_pkg::BYTE_W-1:0]    rx_byte,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    kind,
  output logic [efd_pkg::BYTE_W-1:0]    payload_byte,
  output logic [efd_pkg::IDX_W-1:0]     byte_index,
  output logic [2:0]                    status,
  output logic [efd_pkg::LEN_W-1:0]     frame_length,
  // configuration write port
  input  logic                          cfg_write,
  input  logic [efd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [efd_pkg::CFG_W-1:0]     cfg_data
);
  import efd_pkg::*;

  // configuration registers
  logic [CFG_W-1:0]  max_length;
  logic [CFG_W-1:0]  min_length;

  // input register
  logic              in_reg_valid;
  logic [BYTE_W-1:0] in_reg_byte;

  logic              out_free;
  logic              fire;
  logic              in_take;
  res_t              res;

  // item in the input register moves on when the result register has room
  assign fire     = in_reg_valid && out_free;
  assign in_stall = in_reg_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RST;
      min_length <= MIN_LENGTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAX_LENGTH: max_length <= cfg_data;
        REG_MIN_LENGTH: min_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_reg_byte <= rx_byte;
    end
  end

  efd_frame_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .rx_byte    (in_reg_byte),
    .max_length (max_length),
    .min_length (min_length),
    .res        (res)
  );

  efd_result_reg u_result (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .out_stall    (out_stall),
    .free         (out_free),
    .out_valid    (out_valid),
    .kind         (kind),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .status       (status),
    .frame_length (frame_length)
  );

endmodule

// ===== hw/rtl/efd_frame_core.sv =====
module efd_frame_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  logic [efd_pkg::BYTE_W-1:0] rx_byte,
  input  logic [efd_pkg::CFG_W-1:0]  max_length,
  input  logic [efd_pkg::CFG_W-1:0]  min_length,
  output efd_pkg::res_t              res
);
  import efd_pkg::*;

  logic              in_frame, in_frame_next;
  logic              escape_pending, escape_pending_next;
  logic [LEN_W-1:0]  byte_count, byte_count_next;
  logic [BYTE_W-1:0] header_sum, header_sum_next;
  logic [BYTE_W-1:0] body_sum, body_sum_next;

  logic [LEN_W-1:0]  limit;
  esc_t              esc;
  logic              do_take;
  logic              do_abort;
  status_t           abort_status;
  logic [BYTE_W-1:0] data_byte;

  assign limit = (max_length > MAX_FRAME_LEN) ? MAX_FRAME_LEN : max_length;
  assign esc   = esc_decode(rx_byte);

  always_comb begin
    in_frame_next       = in_frame;
    escape_pending_next = escape_pending;
    byte_count_next     = byte_count;
    header_sum_next     = header_sum;
    body_sum_next       = body_sum;
    do_take             = 1'b0;
    do_abort            = 1'b0;
    abort_status        = ST_ESC;
    data_byte           = rx_byte;
    res                 = '0;
    res.kind            = KIND_BYTE;
    res.status          = ST_OK;

    if (fire) begin
      if (rx_byte == CH_START) begin
        in_frame_next       = 1'b1;
        escape_pending_next = 1'b0;
        byte_count_next     = '0;
        header_sum_next     = '0;
        body_sum_next       = '0;
      end else if (in_frame) begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
          data_byte           = esc.plain;
          do_take             = esc.hit;
          do_abort            = !esc.hit;
        end else if (rx_byte == CH_ESC) begin
          escape_pending_next = 1'b1;
        end else if (rx_byte == CH_STOP) begin
          in_frame_next    = 1'b0;
          res.valid        = 1'b1;
          res.kind         = KIND_END;
          res.frame_length = byte_count;
          priority if (byte_count < min_length) res.status = ST_SHORT;
          else if (header_sum != '0)            res.status = ST_HDR;
          else if (body_sum != '0)              res.status = ST_BODY;
          else                                  res.status = ST_OK;
        end else if (rx_byte != CH_SHAKE) begin
          do_take = 1'b1;
        end
      end
    end

    // overlong check applies to plain and escaped bytes alike
    if (do_take && byte_count >= limit) begin
      do_take      = 1'b0;
      do_abort     = 1'b1;
      abort_status = ST_LONG;
    end

    if (do_take) begin
      if (byte_count < LEN_W'(3)) begin
        header_sum_next = header_sum + data_byte;
      end else begin
        body_sum_next = body_sum + data_byte;
      end
      byte_count_next  = byte_count + LEN_W'(1);
      res.valid        = 1'b1;
      res.kind         = KIND_BYTE;
      res.payload_byte = data_byte;
      res.byte_index   = byte_count[IDX_W-1:0];
    end

    if (do_abort) begin
      in_frame_next       = 1'b0;
      escape_pending_next = 1'b0;
      res.valid           = 1'b1;
      res.kind            = KIND_ABORT;
      res.status          = abort_status;
      res.frame_length    = byte_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      escape_pending <= 1'b0;
      byte_count     <= '0;
      header_sum     <= '0;
      body_sum       <= '0;
    end else begin
      in_frame       <= in_frame_next;
      escape_pending <= escape_pending_next;
      byte_count     <= byte_count_next;
      header_sum     <= header_sum_next;
      body_sum       <= body_sum_next;
    end
  end

  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == KIND_BYTE |-> res.status == ST_OK)
    else $error("payload byte carries an error status");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= MAX_FRAME_LEN)
    else $error("byte count beyond frame size");

  a_no_esc_idle: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> !escape_pending)
    else $error("escape pending outside a frame");

  a_start: assert property (@(posedge clk) disable iff (rst)
    fire && rx_byte == CH_START |=> in_frame && byte_count == '0 && !escape_pending)
    else $error("start byte did not open a clean frame");

endmodule

// ===== hw/rtl/efd_result_reg.sv =====
module efd_result_reg (
  input  logic                       clk,
  input  logic                       rst,
  input  efd_pkg::res_t              res,
  input  logic                       out_stall,
  output logic                       free,
  output logic                       out_valid,
  output logic [1:0]                 kind,
  output logic [efd_pkg::BYTE_W-1:0] payload_byte,
  output logic [efd_pkg::IDX_W-1:0]  byte_index,
  output logic [2:0]                 status,
  output logic [efd_pkg::LEN_W-1:0]  frame_length
);
  import efd_pkg::*;

  res_t held;

  // register can take a new result when empty or being drained
  assign free = !held.valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (free) begin
      held <= res;
    end
  end

  assign out_valid    = held.valid;
  assign kind         = held.kind;
  assign payload_byte = held.payload_byte;
  assign byte_index   = held.byte_index;
  assign status       = held.status;
  assign frame_length = held.frame_length;

endmodule
